/* design/rtia_pkg.sv */
package rtia_pkg;

  localparam int unsigned RateW = 4;
  localparam int unsigned IncW  = 21;
  localparam int unsigned FracW = 10;
  localparam int unsigned ReqW  = 32;
  localparam int unsigned CfgAddrW = 1;

  localparam logic [RateW-1:0] RateLo = 4'd1;
  localparam logic [RateW-1:0] RateHi = 4'd13;
  localparam logic [FracW:0]   PartsPerUnit = 11'd1000;

  localparam logic [RateW-1:0] MinRateRst = 4'd6;
  localparam logic [RateW-1:0] MaxRateRst = 4'd10;
  localparam logic [RateW-1:0] RateRst    = 4'd10;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_MIN_RATE = 1'b0,
    CFG_MAX_RATE = 1'b1
  } cfg_addr_e;

  typedef struct packed {
    logic [IncW-1:0]  tick_increment;
    logic [IncW-1:0]  granted_increment;
    logic [RateW-1:0] rate_code;
    logic             rate_written;
  } result_t;

  // Whole part of the tick period, in 100 ns units
  function automatic logic [IncW-1:0] whole_of(input logic [RateW-1:0] rate);
    logic [IncW-1:0] w;
    case (rate)
      4'd1:    w = 21'd305;
      4'd2:    w = 21'd610;
      4'd3:    w = 21'd1220;
      4'd4:    w = 21'd2441;
      4'd5:    w = 21'd4882;
      4'd6:    w = 21'd9765;
      4'd7:    w = 21'd19531;
      4'd8:    w = 21'd39062;
      4'd9:    w = 21'd78125;
      4'd10:   w = 21'd156250;
      4'd11:   w = 21'd312500;
      4'd12:   w = 21'd625000;
      4'd13:   w = 21'd1250000;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Remainder of the tick period, in thousandths of a 100 ns unit
  function automatic logic [FracW-1:0] frac_of(input logic [RateW-1:0] rate);
    logic [FracW-1:0] f;
    case (rate)
      4'd1:    f = 10'd175;
      4'd2:    f = 10'd351;
      4'd3:    f = 10'd703;
      4'd4:    f = 10'd406;
      4'd5:    f = 10'd812;
      4'd6:    f = 10'd625;
      4'd7:    f = 10'd250;
      4'd8:    f = 10'd500;
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [RateW-1:0] clamp_rate(input logic [RateW-1:0] rate);
    logic [RateW-1:0] r;
    r = rate;
    if (rate < RateLo) r = RateLo;
    if (rate > RateHi) r = RateHi;
    return r;
  endfunction

endpackage

/* design/rtia_rate_sel.sv */
module rtia_rate_sel (
  input  logic [rtia_pkg::RateW-1:0] min_rate_i,
  input  logic [rtia_pkg::RateW-1:0] max_rate_i,
  input  logic [rtia_pkg::ReqW-1:0]  req_i,
  output logic [rtia_pkg::RateW-1:0] rate_o
);
  import rtia_pkg::*;

  logic [RateW-1:0] lo;
  logic [RateW-1:0] hi;

  assign lo = clamp_rate(min_rate_i);
  assign hi = clamp_rate(max_rate_i);

  // Periods grow with the rate, so the fitting rates above the minimum are contiguous:
  // keep the last one that still fits.
  always_comb begin
    rate_o = lo;
    for (int k = 1; k <= int'(RateHi); k++) begin
      if (RateW'(k) > lo && RateW'(k) <= hi &&
          {{(ReqW-IncW){1'b0}}, whole_of(RateW'(k))} <= req_i) begin
        rate_o = RateW'(k);
      end
    end
  end

endmodule

/* design/rtia_tick_acc.sv */
module rtia_tick_acc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       op_i,
  input  logic [rtia_pkg::ReqW-1:0]  req_i,
  input  logic [rtia_pkg::RateW-1:0] min_rate_i,
  input  logic [rtia_pkg::RateW-1:0] max_rate_i,
  output rtia_pkg::result_t          result_o
);
  import rtia_pkg::*;

  logic [RateW-1:0] cur_rate_q, cur_rate_d;
  logic [FracW-1:0] run_frac_q, run_frac_d;
  logic             pend_q, pend_d;
  logic [RateW-1:0] next_rate_q, next_rate_d;

  logic [RateW-1:0] sel_rate;
  logic [FracW:0]   frac_sum;
  logic             carry;

  rtia_rate_sel u_rate_sel (
    .min_rate_i (min_rate_i),
    .max_rate_i (max_rate_i),
    .req_i      (req_i),
    .rate_o     (sel_rate)
  );

  assign frac_sum = {1'b0, run_frac_q} + {1'b0, frac_of(cur_rate_q)};
  assign carry    = frac_sum >= PartsPerUnit;

  always_comb begin
    cur_rate_d  = cur_rate_q;
    run_frac_d  = run_frac_q;
    pend_d      = pend_q;
    next_rate_d = next_rate_q;
    result_o    = '0;
    if (op_i == 1'b0) begin
      result_o.tick_increment = whole_of(cur_rate_q) + {{(IncW-1){1'b0}}, carry};
      run_frac_d = carry ? FracW'(frac_sum - PartsPerUnit) : FracW'(frac_sum);
      // apply the pending rate after the tick has been accounted at the old one
      if (pend_q) begin
        cur_rate_d            = next_rate_q;
        pend_d                = 1'b0;
        result_o.rate_written = 1'b1;
      end
    end else begin
      next_rate_d                = sel_rate;
      pend_d                     = 1'b1;
      result_o.granted_increment = whole_of(sel_rate);
    end
    result_o.rate_code = cur_rate_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_rate_q  <= RateRst;
      run_frac_q  <= '0;
      pend_q      <= 1'b0;
      next_rate_q <= RateRst;
    end else if (en_i) begin
      cur_rate_q  <= cur_rate_d;
      run_frac_q  <= run_frac_d;
      pend_q      <= pend_d;
      next_rate_q <= next_rate_d;
    end
  end

endmodule

/* design/rtc_tick_increment_accumulator.sv */
// Channel | Handshake                  | Payload
// input   | in_valid_i / in_ready_o    | op_i, requested_increment_i
// output  | out_valid_o / out_ready_i  | tick_increment_o, granted_increment_o,
//         |                            | rate_code_o, rate_written_o
// config  | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One item per cycle unless the output stalls; results pass stage one, then stage two.
// Stage one registers the item, stage two runs the period table lookup, the
// fraction add and the rate search, and updates the rate state.
// Reset clears both stages, restores rate 10 and rate limits 6 and 10.
// A stalled output holds its result; stage one keeps taking items while it can move up.
module rtc_tick_increment_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [31:0]                   requested_increment_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [20:0]                   tick_increment_o,
  output logic [20:0]                   granted_increment_o,
  output logic [3:0]                    rate_code_o,
  output logic                          rate_written_o,
  input  logic                          cfg_we_i,
  input  logic [rtia_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  logic [rtia_pkg::RateW-1:0]    cfg_data_i
);
  import rtia_pkg::*;

  logic [RateW-1:0] min_rate_q;
  logic [RateW-1:0] max_rate_q;

  logic             s1_valid_q;
  logic             s1_op_q;
  logic [ReqW-1:0]  s1_req_q;
  logic             s1_adv;

  logic             out_valid_q;
  result_t          out_q;
  result_t          res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q <= MinRateRst;
      max_rate_q <= MaxRateRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_e'(cfg_idx_i))
        CFG_MIN_RATE: min_rate_q <= cfg_data_i;
        CFG_MAX_RATE: max_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q  <= op_i;
      s1_req_q <= requested_increment_i;
    end
  end

  rtia_tick_acc u_tick_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (s1_adv),
    .op_i       (s1_op_q),
    .req_i      (s1_req_q),
    .min_rate_i (min_rate_q),
    .max_rate_i (max_rate_q),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign tick_increment_o    = out_q.tick_increment;
  assign granted_increment_o = out_q.granted_increment;
  assign rate_code_o         = out_q.rate_code;
  assign rate_written_o      = out_q.rate_written;

endmodule

/* design/rtia_checker.sv */
module rtia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] tick_increment_o,
  input logic [20:0] granted_increment_o,
  input logic [3:0]  rate_code_o,
  input logic        rate_written_o
);

  // every result is either a tick or a grant, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((tick_increment_o != 21'd0) != (granted_increment_o != 21'd0)))
    else $error("result is neither or both of tick and grant");

  // only a tick applies a rate change
  a_written_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rate_written_o) |-> (granted_increment_o == 21'd0))
    else $error("rate change flagged on a request");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rate_code_o >= 4'd1 && rate_code_o <= 4'd13))
    else $error("rate code out of range");

  // hold the result while the output is stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(tick_increment_o) && $stable(granted_increment_o) &&
       $stable(rate_code_o) && $stable(rate_written_o)))
    else $error("stalled result changed");

endmodule

bind rtc_tick_increment_accumulator rtia_checker u_rtia_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .tick_increment_o    (tick_increment_o),
  .granted_increment_o (granted_increment_o),
  .rate_code_o         (rate_code_o),
  .rate_written_o      (rate_written_o)
);
